FILE: sv/hsv565_pkg.sv
// Shared types and constants for the HSV to RGB565 converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hsv565_pkg;

    localparam int unsigned HUE_MOD      = 360;
    localparam int unsigned SECTOR_DEG   = 60;
    localparam int unsigned FULL_LEVEL   = 255;
    localparam int unsigned SECTOR_SCALE = FULL_LEVEL * SECTOR_DEG;   // 15300
    localparam int unsigned QUARTER_SCALE = SECTOR_SCALE / 4;         // 3825

    // floor(x/255) ~ (x*257) >> 16, low by at most one for x < 2^16
    localparam int unsigned P_RECIP  = 257;
    localparam int unsigned P_SHIFT  = 16;
    // floor(y/3825) ~ (y*RECIP) >> 28, low by at most one for y < 2^20
    localparam int unsigned QT_SHIFT = 28;
    localparam int unsigned QT_RECIP = (2**QT_SHIFT) / QUARTER_SCALE;

    localparam int unsigned RB_MASK = 'h1f;
    localparam int unsigned G_MASK  = 'h3f;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } hsv565_sector_t;

    // hue split into sector and offset
    typedef struct packed {
        hsv565_sector_t sector;
        logic [5:0]     h;
        logic [7:0]     sat;
        logic [7:0]     val;
    } hsv565_pos_t;

    // numerators ahead of the divides; q and t already divided by 4
    typedef struct packed {
        hsv565_sector_t sector;
        logic [7:0]     val;
        logic [15:0]    p_num;
        logic [19:0]    q_num;
        logic [19:0]    t_num;
    } hsv565_num_t;

endpackage

FILE: sv/hsv_to_rgb565_converter.sv
// Top level of the HSV to RGB565 converter: six-stage pipeline.
// Depends on hsv565_pkg, hsv565_sector, hsv565_product, hsv565_divide.
//
//  channel | signals                                  | dir
//  --------+------------------------------------------+-----
//  input   | in_valid, in_stall, hue_deg, sat_level,  | in
//          | val_level                                |
//  output  | out_valid, out_stall, rgb565_word        | out
//
// One word accepted per clock while in_stall is low; six register stages (hue mod, sector,
// products, numerators, reciprocal multiply, correction and packing).
// Reset (rst_n low, async) empties the pipeline; no datapath state.
// out_stall holds the full stages in place while empty stages keep filling;
// in_stall rises only when every stage holds a word.
`timescale 1ns / 1ps

module hsv_to_rgb565_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [9:0]  hue_deg,
    input  logic [7:0]  sat_level,
    input  logic [7:0]  val_level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] rgb565_word
);
    import hsv565_pkg::*;

    logic        pos_valid, pos_stall;
    hsv565_pos_t pos;
    logic        num_valid, num_stall;
    hsv565_num_t num;

    hsv565_sector u_sector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .hue_deg   (hue_deg),
        .sat_level (sat_level),
        .val_level (val_level),
        .out_valid (pos_valid),
        .out_stall (pos_stall),
        .out_pos   (pos)
    );

    hsv565_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pos_valid),
        .in_stall  (pos_stall),
        .in_pos    (pos),
        .out_valid (num_valid),
        .out_stall (num_stall),
        .out_num   (num)
    );

    hsv565_divide u_divide (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (num_valid),
        .in_stall    (num_stall),
        .in_num      (num),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rgb565_word (rgb565_word)
    );

endmodule

FILE: sv/hsv565_sector.sv
// Hue reduction: mod 360, then sector and offset inside the sector.
// Depends on hsv565_pkg. Two register stages.
`timescale 1ns / 1ps

module hsv565_sector (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [9:0]              hue_deg,
    input  logic [7:0]              sat_level,
    input  logic [7:0]              val_level,
    output logic                    out_valid,
    input  logic                    out_stall,
    output hsv565_pkg::hsv565_pos_t out_pos
);
    import hsv565_pkg::*;

    logic        vld_a_reg;
    logic [8:0]  hue_a_reg, hue_a_next;
    logic [7:0]  sat_a_reg, val_a_reg;
    logic        vld_b_reg;
    hsv565_pos_t pos_b_reg, pos_b_next;
    logic        ready_a, ready_b;

    assign ready_b   = !vld_b_reg || !out_stall;
    assign ready_a   = !vld_a_reg || ready_b;
    assign in_stall  = !ready_a;
    assign out_valid = vld_b_reg;
    assign out_pos   = pos_b_reg;

    always_comb
    begin
        if (hue_deg >= 10'(2 * HUE_MOD))
            hue_a_next = 9'(hue_deg - 10'(2 * HUE_MOD));
        else if (hue_deg >= 10'(HUE_MOD))
            hue_a_next = 9'(hue_deg - 10'(HUE_MOD));
        else
            hue_a_next = hue_deg[8:0];
    end

    always_comb
    begin
        pos_b_next.sat = sat_a_reg;
        pos_b_next.val = val_a_reg;
        if (hue_a_reg >= 9'(5 * SECTOR_DEG))
        begin
            pos_b_next.sector = SEC_MAG_RED;
            pos_b_next.h      = 6'(hue_a_reg - 9'(5 * SECTOR_DEG));
        end
        else if (hue_a_reg >= 9'(4 * SECTOR_DEG))
        begin
            pos_b_next.sector = SEC_BLU_MAG;
            pos_b_next.h      = 6'(hue_a_reg - 9'(4 * SECTOR_DEG));
        end
        else if (hue_a_reg >= 9'(3 * SECTOR_DEG))
        begin
            pos_b_next.sector = SEC_CYN_BLU;
            pos_b_next.h      = 6'(hue_a_reg - 9'(3 * SECTOR_DEG));
        end
        else if (hue_a_reg >= 9'(2 * SECTOR_DEG))
        begin
            pos_b_next.sector = SEC_GRN_CYN;
            pos_b_next.h      = 6'(hue_a_reg - 9'(2 * SECTOR_DEG));
        end
        else if (hue_a_reg >= 9'(SECTOR_DEG))
        begin
            pos_b_next.sector = SEC_YEL_GRN;
            pos_b_next.h      = 6'(hue_a_reg - 9'(SECTOR_DEG));
        end
        else
        begin
            pos_b_next.sector = SEC_RED_YEL;
            pos_b_next.h      = hue_a_reg[5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
                vld_a_reg <= in_valid;
            if (ready_b)
                vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            hue_a_reg <= hue_a_next;
            sat_a_reg <= sat_level;
            val_a_reg <= val_level;
        end
        if (ready_b && vld_a_reg)
            pos_b_reg <= pos_b_next;
    end

endmodule

FILE: sv/hsv565_product.sv
// Products forming the p, q and t numerators.
// Depends on hsv565_pkg. Two register stages, one multiply level each.
`timescale 1ns / 1ps

module hsv565_product (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  hsv565_pkg::hsv565_pos_t in_pos,
    output logic                    out_valid,
    input  logic                    out_stall,
    output hsv565_pkg::hsv565_num_t out_num
);
    import hsv565_pkg::*;

    logic           vld_c_reg;
    hsv565_sector_t sector_c_reg;
    logic [7:0]     val_c_reg;
    logic [15:0]    p_num_c_reg, p_num_c_next;
    logic [13:0]    sh_c_reg, sh_c_next;     // s*h
    logic [13:0]    sr_c_reg, sr_c_next;     // s*(60-h)
    logic           vld_d_reg;
    hsv565_num_t    num_d_reg, num_d_next;
    logic [13:0]    zq, zt;
    logic [21:0]    yq, yt;
    logic           ready_c, ready_d;

    assign ready_d   = !vld_d_reg || !out_stall;
    assign ready_c   = !vld_c_reg || ready_d;
    assign in_stall  = !ready_c;
    assign out_valid = vld_d_reg;
    assign out_num   = num_d_reg;

    always_comb
    begin
        p_num_c_next = in_pos.val * (8'(FULL_LEVEL) - in_pos.sat);
        sh_c_next    = in_pos.sat * in_pos.h;
        sr_c_next    = in_pos.sat * (6'(SECTOR_DEG) - in_pos.h);
    end

    always_comb
    begin
        zq = 14'(SECTOR_SCALE) - sh_c_reg;
        zt = 14'(SECTOR_SCALE) - sr_c_reg;
        yq = val_c_reg * zq;
        yt = val_c_reg * zt;
        num_d_next.sector = sector_c_reg;
        num_d_next.val    = val_c_reg;
        num_d_next.p_num  = p_num_c_reg;
        // floor(y/15300) == floor(floor(y/4)/3825)
        num_d_next.q_num  = yq[21:2];
        num_d_next.t_num  = yt[21:2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end
        else
        begin
            if (ready_c)
                vld_c_reg <= in_valid;
            if (ready_d)
                vld_d_reg <= vld_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_c && in_valid)
        begin
            sector_c_reg <= in_pos.sector;
            val_c_reg    <= in_pos.val;
            p_num_c_reg  <= p_num_c_next;
            sh_c_reg     <= sh_c_next;
            sr_c_reg     <= sr_c_next;
        end
        if (ready_d && vld_c_reg)
            num_d_reg <= num_d_next;
    end

endmodule

FILE: sv/hsv565_divide.sv
// Constant divides by reciprocal with one-step correction, then
// sector channel mapping and RGB565 packing. Depends on hsv565_pkg.
`timescale 1ns / 1ps

module hsv565_divide (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  hsv565_pkg::hsv565_num_t in_num,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [15:0]             rgb565_word
);
    import hsv565_pkg::*;

    logic           vld_e_reg;
    hsv565_sector_t sector_e_reg;
    logic [7:0]     val_e_reg;
    logic [15:0]    p_num_e_reg;
    logic [19:0]    q_num_e_reg, t_num_e_reg;
    logic [7:0]     p_est_e_reg, q_est_e_reg, t_est_e_reg;
    logic [7:0]     p_est_e_next, q_est_e_next, t_est_e_next;
    logic [24:0]    p_prod;
    logic [36:0]    q_prod, t_prod;
    logic           vld_f_reg;
    logic [15:0]    word_f_reg, word_f_next;
    logic [15:0]    p_rem;
    logic [19:0]    q_rem, t_rem;
    logic [7:0]     p_val, q_val, t_val;
    logic [7:0]     r_ch, g_ch, b_ch;
    logic           ready_e, ready_f;

    assign ready_f     = !vld_f_reg || !out_stall;
    assign ready_e     = !vld_e_reg || ready_f;
    assign in_stall    = !ready_e;
    assign out_valid   = vld_f_reg;
    assign rgb565_word = word_f_reg;

    always_comb
    begin
        p_prod       = in_num.p_num * 9'(P_RECIP);
        q_prod       = in_num.q_num * 17'(QT_RECIP);
        t_prod       = in_num.t_num * 17'(QT_RECIP);
        p_est_e_next = p_prod[P_SHIFT +: 8];
        q_est_e_next = q_prod[QT_SHIFT +: 8];
        t_est_e_next = t_prod[QT_SHIFT +: 8];
    end

    always_comb
    begin
        p_rem = p_num_e_reg - 16'(p_est_e_reg * 16'(FULL_LEVEL));
        q_rem = q_num_e_reg - 20'(q_est_e_reg * 20'(QUARTER_SCALE));
        t_rem = t_num_e_reg - 20'(t_est_e_reg * 20'(QUARTER_SCALE));
        p_val = (p_rem >= 16'(FULL_LEVEL))    ? p_est_e_reg + 8'd1 : p_est_e_reg;
        q_val = (q_rem >= 20'(QUARTER_SCALE)) ? q_est_e_reg + 8'd1 : q_est_e_reg;
        t_val = (t_rem >= 20'(QUARTER_SCALE)) ? t_est_e_reg + 8'd1 : t_est_e_reg;

        case (sector_e_reg)
            SEC_RED_YEL: begin r_ch = val_e_reg; g_ch = t_val;     b_ch = p_val;     end
            SEC_YEL_GRN: begin r_ch = q_val;     g_ch = val_e_reg; b_ch = p_val;     end
            SEC_GRN_CYN: begin r_ch = p_val;     g_ch = val_e_reg; b_ch = t_val;     end
            SEC_CYN_BLU: begin r_ch = p_val;     g_ch = q_val;     b_ch = val_e_reg; end
            SEC_BLU_MAG: begin r_ch = t_val;     g_ch = p_val;     b_ch = val_e_reg; end
            default:     begin r_ch = val_e_reg; g_ch = p_val;     b_ch = q_val;     end
        endcase

        word_f_next = {5'(8'(r_ch >> 3) & 8'(RB_MASK)),
                       6'(8'(g_ch >> 2) & 8'(G_MASK)),
                       5'(8'(b_ch >> 3) & 8'(RB_MASK))};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_e_reg <= 1'b0;
            vld_f_reg <= 1'b0;
        end
        else
        begin
            if (ready_e)
                vld_e_reg <= in_valid;
            if (ready_f)
                vld_f_reg <= vld_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_e && in_valid)
        begin
            sector_e_reg <= in_num.sector;
            val_e_reg    <= in_num.val;
            p_num_e_reg  <= in_num.p_num;
            q_num_e_reg  <= in_num.q_num;
            t_num_e_reg  <= in_num.t_num;
            p_est_e_reg  <= p_est_e_next;
            q_est_e_reg  <= q_est_e_next;
            t_est_e_reg  <= t_est_e_next;
        end
        if (ready_f && vld_e_reg)
            word_f_reg <= word_f_next;
    end

endmodule
